// File: hdl/hvd_pkg.sv
package hvd_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int DIST_W = 28;

    // Angles are carried in units of 1e-7/16 degree.
    localparam int ANG_W  = 38;
    localparam int XY_W   = 34;
    localparam int TRIG_W = 32;
    localparam int SQ_W   = 63;
    localparam int SQ_STEPS = 32;
    localparam int ZP_W   = 36;
    localparam int PROD_W = 62;

    localparam logic signed [ANG_W-1:0] ANG_TURN    = 38'sd57600000000;
    localparam logic signed [ANG_W-1:0] ANG_HALF    = 38'sd28800000000;
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = 38'sd14400000000;

    localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [TRIG_W:0] ONE_Q30  = 33'sd1073741824;

    localparam logic [25:0]       DM_MULT  = 26'd59697322;
    localparam logic [PROD_W-1:0] DM_ROUND = 62'd2147483648;
    localparam logic [29:0]       DIST_MAX = 30'd200200000;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [0:31] = '{
        38'sd7200000000, 38'sd4250408188, 38'sd2245798955, 38'sd1140002616,
        38'sd572213500,  38'sd286385697,  38'sd143227794,  38'sd71618267,
        38'sd35809680,   38'sd17904908,   38'sd8952463,    38'sd4476232,
        38'sd2238116,    38'sd1119058,    38'sd559529,     38'sd279765,
        38'sd139882,     38'sd69941,      38'sd34971,      38'sd17485,
        38'sd8743,       38'sd4371,       38'sd2186,       38'sd1093,
        38'sd546,        38'sd273,        38'sd137,        38'sd68,
        38'sd34,         38'sd17,         38'sd9,          38'sd4
    };

endpackage

// File: hdl/haversine_distance.sv
// Great-circle distance between a current and a target position.
// Input channel: in_valid/in_stall carry current_lat, current_lon, target_lat
// and target_lon in signed units of 1e-7 degree. A transfer happens on a
// rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carry distance_dm (decimeters,
// saturated at 200200000) and target_missing. A target latitude or
// longitude of zero gives distance 0 with target_missing set.
// The block is a single pipeline that takes one position pair per cycle
// while the output is not stalled. It is built from an input register,
// four parallel sine/cosine CORDIC pipes, three multiply stages, two
// parallel 32-stage square-root pipes, an arctangent CORDIC pipe and two
// scaling stages.
// When a result is waiting and out_stall is high, the whole pipeline holds
// and in_stall goes high in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, so the pipeline comes up empty and
// out_valid low; it is ready for input in the first cycle after reset.
module haversine_distance (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [hvd_pkg::LAT_W-1:0]    current_lat,
    input  logic signed [hvd_pkg::LON_W-1:0]    current_lon,
    input  logic signed [hvd_pkg::LAT_W-1:0]    target_lat,
    input  logic signed [hvd_pkg::LON_W-1:0]    target_lon,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hvd_pkg::DIST_W-1:0]          distance_dm,
    output logic                                target_missing
);
    import hvd_pkg::*;

    logic en;

    logic                    s0_valid_reg;
    logic                    s0_miss_reg;
    logic signed [ANG_W-1:0] s0_dphi_reg;
    logic signed [ANG_W-1:0] s0_dlam_reg;
    logic signed [ANG_W-1:0] s0_lat1_reg;
    logic signed [ANG_W-1:0] s0_lat2_reg;
    logic signed [LON_W-1:0] dlat;
    logic signed [LON_W:0]   dlon;

    logic                     sc_valid;
    logic                     sc_miss;
    logic signed [TRIG_W-1:0] s_dphi;
    logic signed [TRIG_W-1:0] s_dlam;
    logic signed [TRIG_W-1:0] c_lat1;
    logic signed [TRIG_W-1:0] c_lat2;

    logic                        m1_valid_reg;
    logic                        m1_miss_reg;
    logic signed [TRIG_W-1:0]    m1_p1_reg;
    logic signed [TRIG_W-1:0]    m1_cc_reg;
    logic signed [TRIG_W-1:0]    m1_sl_reg;
    logic signed [2*TRIG_W-1:0]  prod_dphi;
    logic signed [2*TRIG_W-1:0]  prod_cc;
    logic signed [2*TRIG_W-1:0]  prod_sl;

    logic                        m2_valid_reg;
    logic                        m2_miss_reg;
    logic signed [TRIG_W-1:0]    m2_p1_reg;
    logic signed [TRIG_W-1:0]    m2_p2_reg;
    logic signed [2*TRIG_W-1:0]  prod_p2;

    logic                     m3_valid_reg;
    logic                     m3_miss_reg;
    logic [TRIG_W-1:0]        m3_a_reg;
    logic [TRIG_W-1:0]        m3_b_reg;
    logic signed [TRIG_W:0]   a_sum;
    logic signed [TRIG_W:0]   a_clamp;
    logic signed [TRIG_W:0]   b_diff;

    logic              sq_valid;
    logic              sq_miss;
    logic [TRIG_W-1:0] root_y;
    logic [TRIG_W-1:0] root_x;

    logic                    at_valid;
    logic                    at_miss;
    logic signed [ANG_W-1:0] at_ang;

    logic              f1_valid_reg;
    logic              f1_miss_reg;
    logic [PROD_W-1:0] f1_prod_reg;
    logic [ZP_W-1:0]   zpos;

    logic              f2_valid_reg;
    logic              f2_miss_reg;
    logic [DIST_W-1:0] f2_dist_reg;
    logic [PROD_W-1:0] rounded;
    logic [29:0]       dist_full;

    // The pipeline moves unless the output holds a result that is not taken.
    assign en       = ~(f2_valid_reg & out_stall);
    assign in_stall = ~en;

    assign dlat = LON_W'(target_lat) - LON_W'(current_lat);
    assign dlon = (LON_W+1)'(target_lon) - (LON_W+1)'(current_lon);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= in_valid;
    end

    // Differences are half angles (x8); the latitudes are whole angles (x16).
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_miss_reg <= (target_lat == '0) || (target_lon == '0);
            s0_dphi_reg <= ANG_W'(dlat) <<< 3;
            s0_dlam_reg <= ANG_W'(dlon) <<< 3;
            s0_lat1_reg <= ANG_W'(current_lat) <<< 4;
            s0_lat2_reg <= ANG_W'(target_lat) <<< 4;
        end
    end

    hvd_sincos u_sc_dphi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_tag    (s0_miss_reg),
        .in_ang    (s0_dphi_reg),
        .out_valid (sc_valid),
        .out_tag   (sc_miss),
        .out_sin   (s_dphi),
        .out_cos   ()
    );

    hvd_sincos u_sc_dlam (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_tag    (1'b0),
        .in_ang    (s0_dlam_reg),
        .out_valid (),
        .out_tag   (),
        .out_sin   (s_dlam),
        .out_cos   ()
    );

    hvd_sincos u_sc_lat1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_tag    (1'b0),
        .in_ang    (s0_lat1_reg),
        .out_valid (),
        .out_tag   (),
        .out_sin   (),
        .out_cos   (c_lat1)
    );

    hvd_sincos u_sc_lat2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .in_tag    (1'b0),
        .in_ang    (s0_lat2_reg),
        .out_valid (),
        .out_tag   (),
        .out_sin   (),
        .out_cos   (c_lat2)
    );

    assign prod_dphi = (2*TRIG_W)'(s_dphi) * (2*TRIG_W)'(s_dphi);
    assign prod_cc   = (2*TRIG_W)'(c_lat1) * (2*TRIG_W)'(c_lat2);
    assign prod_sl   = (2*TRIG_W)'(s_dlam) * (2*TRIG_W)'(s_dlam);
    assign prod_p2   = (2*TRIG_W)'(m1_cc_reg) * (2*TRIG_W)'(m1_sl_reg);

    assign a_sum   = (TRIG_W+1)'(m2_p1_reg) + (TRIG_W+1)'(m2_p2_reg);
    assign a_clamp = a_sum[TRIG_W] ? '0 : ((a_sum > ONE_Q30) ? ONE_Q30 : a_sum);
    assign b_diff  = ONE_Q30 - a_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= sc_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_miss_reg <= sc_miss;
            m1_p1_reg   <= prod_dphi[TRIG_W+29:30];
            m1_cc_reg   <= prod_cc[TRIG_W+29:30];
            m1_sl_reg   <= prod_sl[TRIG_W+29:30];
            m2_miss_reg <= m1_miss_reg;
            m2_p1_reg   <= m1_p1_reg;
            m2_p2_reg   <= prod_p2[TRIG_W+29:30];
            m3_miss_reg <= m2_miss_reg;
            m3_a_reg    <= a_clamp[TRIG_W-1:0];
            m3_b_reg    <= b_diff[TRIG_W-1:0];
        end
    end

    hvd_sqrt u_sqrt_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m3_valid_reg),
        .in_tag    (m3_miss_reg),
        .in_val    ({1'b0, m3_a_reg, 30'd0}),
        .out_valid (sq_valid),
        .out_tag   (sq_miss),
        .out_root  (root_y)
    );

    hvd_sqrt u_sqrt_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m3_valid_reg),
        .in_tag    (1'b0),
        .in_val    ({1'b0, m3_b_reg, 30'd0}),
        .out_valid (),
        .out_tag   (),
        .out_root  (root_x)
    );

    hvd_atan u_atan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_tag    (sq_miss),
        .in_x      (root_x),
        .in_y      (root_y),
        .out_valid (at_valid),
        .out_tag   (at_miss),
        .out_ang   (at_ang)
    );

    assign zpos      = at_ang[ANG_W-1] ? '0 : at_ang[ZP_W-1:0];
    assign rounded   = f1_prod_reg + DM_ROUND;
    assign dist_full = rounded[PROD_W-1:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= at_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_miss_reg <= at_miss;
            f1_prod_reg <= PROD_W'(zpos) * PROD_W'(DM_MULT);
            f2_miss_reg <= f1_miss_reg;
            if (f1_miss_reg)
                f2_dist_reg <= '0;
            else if (dist_full > DIST_MAX)
                f2_dist_reg <= DIST_MAX[DIST_W-1:0];
            else
                f2_dist_reg <= dist_full[DIST_W-1:0];
        end
    end

    assign out_valid      = f2_valid_reg;
    assign distance_dm    = f2_dist_reg;
    assign target_missing = f2_miss_reg;

endmodule

// File: hdl/hvd_sincos.sv
module hvd_sincos (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic                                in_tag,
    input  logic signed [hvd_pkg::ANG_W-1:0]    in_ang,
    output logic                                out_valid,
    output logic                                out_tag,
    output logic signed [hvd_pkg::TRIG_W-1:0]   out_sin,
    output logic signed [hvd_pkg::TRIG_W-1:0]   out_cos
);
    import hvd_pkg::*;

    logic                    r_valid_reg;
    logic                    r_tag_reg;
    logic signed [ANG_W-1:0] r_ang_reg;
    logic signed [ANG_W-1:0] r_ang_next;
    logic signed [ANG_W-1:0] f_ang_next;
    logic                    f_neg_next;

    logic                    v_reg   [0:CORDIC_STEPS];
    logic                    tag_reg [0:CORDIC_STEPS];
    logic                    neg_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  x_reg   [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  y_reg   [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg   [0:CORDIC_STEPS];

    logic                     o_valid_reg;
    logic                     o_tag_reg;
    logic signed [TRIG_W-1:0] o_sin_reg;
    logic signed [TRIG_W-1:0] o_cos_reg;

    // Bring the angle into the half-open full turn around zero (upper end included).
    always_comb
    begin
        if (in_ang > ANG_HALF)
            r_ang_next = in_ang - ANG_TURN;
        else if (in_ang <= -ANG_HALF)
            r_ang_next = in_ang + ANG_TURN;
        else
            r_ang_next = in_ang;
    end

    // Fold into the right half plane; the cosine changes sign there.
    always_comb
    begin
        f_neg_next = 1'b0;
        f_ang_next = r_ang_reg;
        if (r_ang_reg > ANG_QUARTER)
        begin
            f_ang_next = ANG_HALF - r_ang_reg;
            f_neg_next = 1'b1;
        end
        else if (r_ang_reg < -ANG_QUARTER)
        begin
            f_ang_next = -ANG_HALF - r_ang_reg;
            f_neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            v_reg[0]    <= 1'b0;
        end
        else if (en)
        begin
            r_valid_reg <= in_valid;
            v_reg[0]    <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_ang_reg  <= r_ang_next;
            r_tag_reg  <= in_tag;
            tag_reg[0] <= r_tag_reg;
            neg_reg[0] <= f_neg_next;
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= f_ang_next;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_stage
        logic                    d;
        logic signed [XY_W-1:0]  x_next;
        logic signed [XY_W-1:0]  y_next;
        logic signed [ANG_W-1:0] z_next;

        assign d = ~z_reg[k][ANG_W-1];

        always_comb
        begin
            if (d)
            begin
                x_next = x_reg[k] - (y_reg[k] >>> k);
                y_next = y_reg[k] + (x_reg[k] >>> k);
                z_next = z_reg[k] - ATAN_TAB[k];
            end
            else
            begin
                x_next = x_reg[k] + (y_reg[k] >>> k);
                y_next = y_reg[k] - (x_reg[k] >>> k);
                z_next = z_reg[k] + ATAN_TAB[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]   <= x_next;
                y_reg[k+1]   <= y_next;
                z_reg[k+1]   <= z_next;
                neg_reg[k+1] <= neg_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= v_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_tag_reg <= tag_reg[CORDIC_STEPS];
            o_sin_reg <= y_reg[CORDIC_STEPS][TRIG_W-1:0];
            if (neg_reg[CORDIC_STEPS])
                o_cos_reg <= -(x_reg[CORDIC_STEPS][TRIG_W-1:0]);
            else
                o_cos_reg <= x_reg[CORDIC_STEPS][TRIG_W-1:0];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_tag   = o_tag_reg;
    assign out_sin   = o_sin_reg;
    assign out_cos   = o_cos_reg;

endmodule

// File: hdl/hvd_sqrt.sv
module hvd_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic                        in_tag,
    input  logic [hvd_pkg::SQ_W-1:0]    in_val,
    output logic                        out_valid,
    output logic                        out_tag,
    output logic [hvd_pkg::TRIG_W-1:0]  out_root
);
    import hvd_pkg::*;

    logic            v_reg   [0:SQ_STEPS];
    logic            tag_reg [0:SQ_STEPS];
    logic [SQ_W-1:0] rem_reg [0:SQ_STEPS];
    logic [SQ_W-1:0] res_reg [0:SQ_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            rem_reg[0] <= in_val;
            res_reg[0] <= '0;
        end
    end

    // One result bit per stage, from the top pair of bits down.
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] rem_next;
        logic [SQ_W-1:0] res_next;

        assign trial = res_reg[k] + BIT;

        always_comb
        begin
            if (rem_reg[k] >= trial)
            begin
                rem_next = rem_reg[k] - trial;
                res_next = (res_reg[k] >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                res_reg[k+1] <= res_next;
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[SQ_STEPS];
    assign out_tag   = tag_reg[SQ_STEPS];
    assign out_root  = res_reg[SQ_STEPS][TRIG_W-1:0];

endmodule

// File: hdl/hvd_atan.sv
module hvd_atan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic                               in_tag,
    input  logic [hvd_pkg::TRIG_W-1:0]         in_x,
    input  logic [hvd_pkg::TRIG_W-1:0]         in_y,
    output logic                               out_valid,
    output logic                               out_tag,
    output logic signed [hvd_pkg::ANG_W-1:0]   out_ang
);
    import hvd_pkg::*;

    logic                    v_reg   [0:CORDIC_STEPS];
    logic                    tag_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  x_reg   [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]  y_reg   [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg   [0:CORDIC_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            x_reg[0]   <= signed'(XY_W'(in_x));
            y_reg[0]   <= signed'(XY_W'(in_y));
            z_reg[0]   <= '0;
        end
    end

    // Vectoring: rotate toward the x axis and sum the rotation angles.
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_stage
        logic                    d;
        logic signed [XY_W-1:0]  x_next;
        logic signed [XY_W-1:0]  y_next;
        logic signed [ANG_W-1:0] z_next;

        assign d = ~y_reg[k][XY_W-1];

        always_comb
        begin
            if (d)
            begin
                x_next = x_reg[k] + (y_reg[k] >>> k);
                y_next = y_reg[k] - (x_reg[k] >>> k);
                z_next = z_reg[k] + ATAN_TAB[k];
            end
            else
            begin
                x_next = x_reg[k] - (y_reg[k] >>> k);
                y_next = y_reg[k] + (x_reg[k] >>> k);
                z_next = z_reg[k] - ATAN_TAB[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]   <= x_next;
                y_reg[k+1]   <= y_next;
                z_reg[k+1]   <= z_next;
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS];
    assign out_tag   = tag_reg[CORDIC_STEPS];
    assign out_ang   = z_reg[CORDIC_STEPS];

endmodule
